FILE: rtl/fvld_pkg.sv
package fvld_pkg;

    localparam int PIXEL_W     = 16;
    localparam int POS_W       = 20;
    localparam int SUM_W       = 24;
    localparam int WLEN_W      = 9;
    localparam int VIS_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int OPND_W      = SUM_W + 1;
    localparam int PROD_W      = 2 * OPND_W;
    localparam int REM_W       = PROD_W + 1;
    localparam int QUO_W       = VIS_W + 1;
    localparam int CNT_W       = 5;

    localparam logic [WLEN_W-1:0] WINDOW_MAX = 9'd256;
    localparam logic [CNT_W-1:0]  DIV_LAST   = CNT_W'(QUO_W - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_WIN_A_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_B_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LENGTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_THRESH = 2'd3;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               frame_end;
    } t_in;

    typedef struct packed {
        logic [VIS_W-1:0] visibility_sq;
        logic             locked;
        logic             empty_windows;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ_NUM,
        S_SQ_DEN,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic sq_sel;
        logic load_num;
        logic load_den;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_stat;

endpackage

FILE: rtl/fvld_ctrl.sv
module fvld_ctrl
    import fvld_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_frame_end,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_frame_end) n_state = S_SQ_NUM;
            end
            S_SQ_NUM: n_state = S_SQ_DEN;
            S_SQ_DEN: n_state = S_DIV;
            S_DIV: begin
                if (i_stat.div_last) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_SQ_NUM: o_cmd.load_num = 1'b1;
            S_SQ_DEN: begin
                o_cmd.sq_sel   = 1'b1;
                o_cmd.load_den = 1'b1;
            end
            S_DIV: o_cmd.div_step = 1'b1;
            S_OUT: o_cmd.out_load = out_free;
            default: o_cmd = '0;
        endcase
    end

    // hold the result until the beat is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/fvld_datapath.sv
module fvld_datapath
    import fvld_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in                   i_in,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output t_out                  o_out
);

    logic [POS_W-1:0]  r_win_a_start;
    logic [POS_W-1:0]  r_win_b_start;
    logic [WLEN_W-1:0] r_win_len;
    logic [VIS_W-1:0]  r_thresh;

    logic [POS_W:0]    r_pos, n_pos;
    logic [SUM_W-1:0]  r_sum_a, n_sum_a;
    logic [SUM_W-1:0]  r_sum_b, n_sum_b;

    logic [OPND_W-1:0] r_d, r_s;
    logic [REM_W-1:0]  r_rem;
    logic [PROD_W-1:0] r_den;
    logic [QUO_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_cnt;
    t_out              r_out;

    logic [WLEN_W-1:0] len;
    logic [POS_W-1:0]  pos;
    logic              in_range;
    logic              in_a, in_b;
    logic [POS_W-1:0]  off_a, off_b;
    logic [OPND_W-1:0] sum_s, sum_d;
    logic [OPND_W-1:0] opnd;
    logic [PROD_W-1:0] prod;
    logic              ge;
    logic [REM_W-1:0]  rem_sub;
    logic              s_zero;
    logic [VIS_W-1:0]  vis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_a_start <= '0;
            r_win_b_start <= '0;
            r_win_len     <= '0;
            r_thresh      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIN_A_START: r_win_a_start <= i_cfg_data;
                CFG_WIN_B_START: r_win_b_start <= i_cfg_data;
                CFG_WIN_LENGTH:  r_win_len     <= i_cfg_data[WLEN_W-1:0];
                CFG_LOCK_THRESH: r_thresh      <= i_cfg_data[VIS_W-1:0];
                default: ;
            endcase
        end
    end

    // window test on the current position
    assign len      = (r_win_len > WINDOW_MAX) ? WINDOW_MAX : r_win_len;
    assign pos      = r_pos[POS_W-1:0];
    assign in_range = !r_pos[POS_W];
    assign off_a    = pos - r_win_a_start;
    assign off_b    = pos - r_win_b_start;
    assign in_a     = (pos >= r_win_a_start) && (off_a < POS_W'(len));
    assign in_b     = (pos >= r_win_b_start) && (off_b < POS_W'(len));

    always_comb begin
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        n_pos   = r_pos;
        if (i_cmd.accept && in_range) begin
            if (in_a) n_sum_a = r_sum_a + SUM_W'(i_in.pixel);
            if (in_b) n_sum_b = r_sum_b + SUM_W'(i_in.pixel);
            n_pos = r_pos + 1'b1;
        end
    end

    assign sum_s = {1'b0, n_sum_a} + {1'b0, n_sum_b};
    assign sum_d = (n_sum_a >= n_sum_b) ? {1'b0, n_sum_a - n_sum_b}
                                        : {1'b0, n_sum_b - n_sum_a};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_sum_a <= '0;
            r_sum_b <= '0;
        end else if (i_cmd.accept && i_in.frame_end) begin
            r_pos   <= '0;
            r_sum_a <= '0;
            r_sum_b <= '0;
        end else begin
            r_pos   <= n_pos;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
        end
    end

    // one shared squarer: d*d first, then s*s
    assign opnd = i_cmd.sq_sel ? r_s : r_d;
    assign prod = opnd * opnd;

    assign ge      = r_rem >= {1'b0, r_den};
    assign rem_sub = ge ? (r_rem - {1'b0, r_den}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_in.frame_end) begin
            r_d <= sum_d;
            r_s <= sum_s;
        end
        if (i_cmd.load_num) r_rem <= {1'b0, prod};
        if (i_cmd.load_den) begin
            r_den <= prod;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= {rem_sub[REM_W-2:0], 1'b0};
            r_q   <= {r_q[QUO_W-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.out_load) r_out <= '{visibility_sq: vis,
                                       locked:        !s_zero && (vis > r_thresh),
                                       empty_windows: s_zero};
    end

    // last quotient bit is the rounding bit
    assign s_zero = (r_s == '0);
    assign vis    = s_zero ? '0 : (r_q[QUO_W-1:1] + VIS_W'(r_q[0]));

    assign o_stat.div_last = (r_cnt == DIV_LAST);
    assign o_out           = r_out;

endmodule

FILE: rtl/fringe_visibility_lock_detect.sv
// Fringe visibility lock detector.
// Input channel (i_in_valid / o_in_ready, payload i_in): camera pixels in
// raster order, one beat per pixel, frame_end set on the last pixel. The
// block counts pixel positions itself and sums the two configured windows.
// Output channel (o_out_valid / i_out_ready, payload o_out): one beat per
// frame with the squared visibility in Q1.16, the lock flag and the
// empty-window flag.
// Throughput: one pixel per cycle inside a frame. After the frame-end beat
// o_in_ready drops while the shared squarer forms d*d, then s*s, the
// radix-2 divider produces one quotient bit per step, and the result
// is loaded into the output register.
// If the receiver stalls, the result waits in the output register and new
// pixels are taken; a second frame result waits until the first is taken.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 window A start, 1 window B start, 2 window length, 3 lock threshold).
// Reset (synchronous, active low) clears registers, sums, position and
// the output valid.
module fringe_visibility_lock_detect
    import fvld_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out
);

    t_cmd  cmd;
    t_stat stat;

    fvld_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_frame_end (i_in.frame_end),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fvld_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out       (o_out)
    );

    a_empty_no_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.empty_windows) |->
            (!o_out.locked && o_out.visibility_sq == '0))
        else $error("empty windows reported with lock or nonzero visibility");

    a_vis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.visibility_sq <= VIS_W'(65536)))
        else $error("visibility above one");

    a_frame_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.frame_end) |=> !o_in_ready)
        else $error("input taken during frame-end computation");

    a_lock_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.locked) |-> (o_out.visibility_sq != '0))
        else $error("lock flagged at zero visibility");

endmodule

FILE: verif/fvld_frame_checker.sv
module fvld_frame_checker
    import fvld_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in                   i_in,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out                  i_out,
    input  logic                  i_end,
    output int                    o_fail_count,
    output int                    o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_PIXELS_MAX = 1048576;

    logic [POS_W-1:0]  win_a_start;
    logic [POS_W-1:0]  win_b_start;
    logic [WLEN_W-1:0] win_length;
    logic [VIS_W-1:0]  lock_thresh;

    // one bit wider than a position: the count saturates at the frame limit
    logic [POS_W:0]    pixel_pos;
    logic [SUM_W-1:0]  sum_a;
    logic [SUM_W-1:0]  sum_b;

    t_out frame_results_q[$];
    int   mismatch_count = 0;
    int   leftover_count = 0;
    int   result_total = 0;
    bit   end_done = 1'b0;

    assign o_fail_count   = mismatch_count + leftover_count;
    assign o_result_count = result_total;

    // round(d*d*2^16 / s*s), ties up: floor((2*d*d*2^16 + s*s) / (2*s*s))
    function automatic logic [VIS_W-1:0] visibility_q16(logic [SUM_W-1:0] a,
                                                        logic [SUM_W-1:0] b);
        logic [127:0] d;
        logic [127:0] s;
        logic [127:0] num;
        logic [127:0] den;
        d   = (a >= b) ? a - b : b - a;
        s   = a + b;
        num = (d * d) << 17;
        den = s * s;
        return VIS_W'((num + den) / (den << 1));
    endfunction

    always @(posedge i_clk) begin : watch
        t_out             expected;
        t_out             got;
        logic [WLEN_W-1:0] len;
        if (!i_rst_n) begin
            win_a_start = '0;
            win_b_start = '0;
            win_length  = '0;
            lock_thresh = '0;
            pixel_pos   = '0;
            sum_a       = '0;
            sum_b       = '0;
            frame_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WIN_A_START: win_a_start = i_cfg_data[POS_W-1:0];
                    CFG_WIN_B_START: win_b_start = i_cfg_data[POS_W-1:0];
                    CFG_WIN_LENGTH:  win_length  = i_cfg_data[WLEN_W-1:0];
                    CFG_LOCK_THRESH: lock_thresh = i_cfg_data[VIS_W-1:0];
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready) begin
                len = (win_length > WINDOW_MAX) ? WINDOW_MAX : win_length;
                if (pixel_pos < FRAME_PIXELS_MAX) begin
                    if (pixel_pos >= win_a_start && pixel_pos - win_a_start < len)
                        sum_a = sum_a + i_in.pixel;
                    if (pixel_pos >= win_b_start && pixel_pos - win_b_start < len)
                        sum_b = sum_b + i_in.pixel;
                    pixel_pos = pixel_pos + 1'b1;
                end
                if (i_in.frame_end) begin
                    expected.empty_windows = (sum_a == '0) && (sum_b == '0);
                    expected.visibility_sq = expected.empty_windows ? '0
                                           : visibility_q16(sum_a, sum_b);
                    expected.locked        = !expected.empty_windows
                                           && (expected.visibility_sq > lock_thresh);
                    frame_results_q = {frame_results_q, expected};
                    pixel_pos = '0;
                    sum_a     = '0;
                    sum_b     = '0;
                end
            end

            if (i_out_valid && i_out_ready) begin
                got = i_out;
                result_total <= result_total + 1;
                if (frame_results_q.size() == 0) begin
                    $error("result beat with no frame pending: visibility_sq %0d",
                           got.visibility_sq);
                    mismatch_count++;
                end else begin
                    expected = frame_results_q.pop_front();
                    if (got.visibility_sq !== expected.visibility_sq) begin
                        $error("visibility_sq: expected %0d, got %0d",
                               expected.visibility_sq, got.visibility_sq);
                        mismatch_count++;
                    end
                    if (got.locked !== expected.locked) begin
                        $error("locked: expected %0d, got %0d",
                               expected.locked, got.locked);
                        mismatch_count++;
                    end
                    if (got.empty_windows !== expected.empty_windows) begin
                        $error("empty_windows: expected %0d, got %0d",
                               expected.empty_windows, got.empty_windows);
                        mismatch_count++;
                    end
                end
            end

            if (i_end && !end_done) begin
                end_done = 1'b1;
                if (frame_results_q.size() != 0) begin
                    $error("%0d frame results never arrived", frame_results_q.size());
                    leftover_count = frame_results_q.size();
                end
            end
        end
    end

endmodule

FILE: verif/tb_fringe_visibility_lock_detect.sv
module tb_fringe_visibility_lock_detect
    import fvld_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int LONG_HOLD        = 300;
    localparam int SETTLE_CYCLES    = 30;

    typedef enum int {
        PX_RANDOM,
        PX_ZERO,
        PX_FULL,
        PX_BALANCED,
        PX_DIM
    } t_pixel_style;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in                   in_beat = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out                  out_beat;
    logic                  end_check = 1'b0;
    int                    fail_count;
    int                    result_count;

    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    int frames_sent = 0;
    int cycle_count = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    fringe_visibility_lock_detect DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    fvld_frame_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in           (in_beat),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out          (out_beat),
        .i_end          (end_check),
        .o_fail_count   (fail_count),
        .o_result_count (result_count)
    );

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stalls, one long hold on request, none when quiet
    initial begin
        wait (rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(1, 25)) @(posedge clk);
            end
        end
    end

    task automatic send_pixel(logic [PIXEL_W-1:0] px, logic last);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= '{pixel: px, frame_end: last};
        do @(posedge clk); while (!in_ready);
        if (last)
            frames_sent++;
    endtask

    task automatic send_frame(int n_pix, t_pixel_style style);
        logic [PIXEL_W-1:0] base;
        logic [PIXEL_W-1:0] px;
        base = PIXEL_W'($urandom());
        for (int i = 0; i < n_pix; i++) begin
            case (style)
                PX_ZERO:     px = '0;
                PX_FULL:     px = '1;
                PX_BALANCED: px = base ^ PIXEL_W'($urandom_range(0, 3));
                PX_DIM:      px = PIXEL_W'($urandom_range(0, 15));
                default:     px = PIXEL_W'($urandom());
            endcase
            send_pixel(px, i == n_pix - 1);
        end
    endtask

    // drop valid, wait for every frame result, then wait with the block idle
    task automatic settle();
        in_valid <= 1'b0;
        wait (result_count == frames_sent);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(logic [CFG_DATA_W-1:0] a_start,
                               logic [CFG_DATA_W-1:0] b_start,
                               logic [CFG_DATA_W-1:0] length,
                               logic [CFG_DATA_W-1:0] thresh);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WIN_A_START;
        cfg_data  <= a_start;
        @(posedge clk);
        cfg_index <= CFG_WIN_B_START;
        cfg_data  <= b_start;
        @(posedge clk);
        cfg_index <= CFG_WIN_LENGTH;
        cfg_data  <= length;
        @(posedge clk);
        cfg_index <= CFG_LOCK_THRESH;
        cfg_data  <= thresh;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_start();
        return ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom())
                                           : CFG_DATA_W'($urandom_range(0, 20));
    endfunction

    task automatic random_config();
        logic [CFG_DATA_W-1:0] length;
        logic [CFG_DATA_W-1:0] thresh;
        case ($urandom_range(0, 5))
            0:       length = CFG_DATA_W'(WINDOW_MAX);
            1:       length = CFG_DATA_W'($urandom());
            default: length = CFG_DATA_W'($urandom_range(0, 16));
        endcase
        case ($urandom_range(0, 7))
            0:       thresh = '0;
            1:       thresh = CFG_DATA_W'(65536);
            2:       thresh = CFG_DATA_W'($urandom());
            default: thresh = CFG_DATA_W'($urandom_range(0, 65536));
        endcase
        load_config(pick_start(), pick_start(), length, thresh);
    endtask

    task automatic run_mixed_frames(int n_items);
        int count;
        int n_pix;
        count = 0;
        while (count < n_items) begin
            n_pix = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
            send_frame(n_pix, t_pixel_style'($urandom_range(0, 4)));
            count += n_pix;
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at reset: zero-length windows, both sums empty
        send_pixel(16'hABCD, 1'b1);
        settle();

        load_config(20'd0, 20'd2, 20'd2, 20'd0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h0000, 1'b1);
        send_frame(4, PX_BALANCED);
        send_frame(4, PX_ZERO);
        settle();

        // length clamps to the maximum, windows run past the frame end,
        // threshold above full scale never locks
        load_config(20'd0, 20'd3, 20'hFFFFF, 20'hFFFFF);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h0001, 1'b0);
        send_pixel(16'h8000, 1'b0);
        send_pixel(16'h7FFF, 1'b0);
        send_pixel(16'h5555, 1'b1);
        settle();

        // window B starts beyond the frame; full visibility against the top thresholds
        load_config(20'd1, 20'hFFFFF, 20'd3, 20'd65536);
        send_frame(4, PX_FULL);
        settle();
        load_config(20'd1, 20'hFFFFF, 20'd3, 20'd65535);
        send_frame(4, PX_RANDOM);
        settle();

        for (int phase = 0; phase < 5; phase++) begin
            random_config();
            if (phase == 1)
                hold_req = 1'b1;
            if (phase == 4)
                quiet = 1'b1;
            run_mixed_frames(100);
            settle();
        end

        end_check <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
